// ----- rtl/core/set_mode_median_mean_core_macros.svh -----
// Assertion macros for the set_mode_median_mean_core RTL.
`ifndef SET_MODE_MEDIAN_MEAN_CORE_MACROS_SVH
`define SET_MODE_MEDIAN_MEAN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SMMM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define SMMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SMMM_ASSERT(lbl, expr)
`define SMMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/smmm_pkg.sv -----
package smmm_pkg;
  localparam int MAX_ITEMS = 32;
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = 6;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 22;
  localparam int DVD_W = SUM_W - 1 + 8;
  localparam int REM_W = CNT_W + 1;
  localparam int MED_W = 17;
  localparam int MEAN_W = 24;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_MODE = 1'b1;
endpackage

// ----- rtl/core/smmm_div.sv -----
module smmm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [smmm_pkg::DVD_W-1:0]  dividend,
  input  logic [smmm_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [smmm_pkg::DVD_W-1:0]  quotient
);
  import smmm_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [REM_W-1:0]   trial;
  logic               qbit;

  always_comb begin
    trial = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
    qbit = (trial >= {1'b0, divisor});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DVD_W - 1);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, divisor}) : trial;
      dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quotient = dvd_r;
endmodule

// ----- rtl/core/set_mode_median_mean_core.sv -----
// Channel  Direction  Ports
// input    in         in_valid, in_stall, in_sample, in_is_last
// result   out        out_valid, out_stall, out_kind .. out_last_result
//
// A sample is insertion-sorted into the value memory: for each entry it moves
// past, S_INS_RD reads that entry from memory and S_INS_CMP compares it and
// shifts it up one place.
// Closing a set walks the memory three times; the 29-step serial divider
// computes the mean between the first and second walks. A summary result then
// leaves, followed by one result per mode during the third walk.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds the walk when the next result is due, until it is taken.
module set_mode_median_mean_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_sample,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_kind,
  output logic signed [16:0]             out_median_x2,
  output logic signed [23:0]             out_mean_q8,
  output logic [5:0]                     out_top_frequency,
  output logic [5:0]                     out_mode_count,
  output logic signed [15:0]             out_mode_value,
  output logic                           out_overflowed,
  output logic                           out_last_result
);
  import smmm_pkg::*;
  `include "set_mode_median_mean_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_WALK_RD, S_WALK_ACC, S_DIV, S_SUMMARY
  } state_t;

  logic signed [SAMPLE_W-1:0] mem [MAX_ITEMS];
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic dropped_r, dropped_nxt;
  logic last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [CNT_W-1:0] run_r, run_nxt, top_r, top_nxt, modes_r, modes_nxt;
  logic [CNT_W-1:0] emitted_r, emitted_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] med_a_r, med_a_nxt, med_b_r, med_b_nxt;
  logic signed [MEAN_W-1:0] mean_r, mean_nxt;
  logic div_start_r, div_start_nxt;
  logic div_done;
  logic [DVD_W-1:0] div_q;
  logic [DVD_W-1:0] dividend;
  logic [SUM_W-1:0] sum_mag;

  logic out_valid_r, out_valid_nxt;
  logic out_kind_r, out_kind_nxt;
  logic signed [MED_W-1:0] out_med_r, out_med_nxt;
  logic signed [MEAN_W-1:0] out_mean_r, out_mean_nxt;
  logic [CNT_W-1:0] out_top_r, out_top_nxt, out_modes_r, out_modes_nxt;
  logic signed [SAMPLE_W-1:0] out_val_r, out_val_nxt;
  logic out_ovf_r, out_ovf_nxt;
  logic out_last_r, out_last_nxt;

  logic out_free;
  logic [CNT_W-1:0] run_cur;
  logic [CNT_W-1:0] half;
  logic signed [MEAN_W-1:0] mean_mag;
  logic signed [MED_W-1:0] med_x2;

  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dividend = {sum_mag[SUM_W-2:0], 8'd0};
  assign out_free = !out_valid_r || !out_stall;
  assign half = count_r >> 1;
  assign run_cur = (idx_r == '0) ? CNT_W'(1)
                 : ((rdata_r == prev_r) ? run_r + 1'b1 : CNT_W'(1));
  assign mean_mag = MEAN_W'(div_q[MEAN_W-1:0]);
  assign med_x2 = count_r[0] ? (MED_W'(med_b_r) + MED_W'(med_b_r))
                             : (MED_W'(med_a_r) + MED_W'(med_b_r));

  smmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    dropped_nxt = dropped_r;
    last_nxt = last_r;
    val_nxt = val_r;
    pos_nxt = pos_r;
    pass_nxt = pass_r;
    idx_nxt = idx_r;
    prev_nxt = prev_r;
    run_nxt = run_r;
    top_nxt = top_r;
    modes_nxt = modes_r;
    emitted_nxt = emitted_r;
    sum_nxt = sum_r;
    med_a_nxt = med_a_r;
    med_b_nxt = med_b_r;
    mean_nxt = mean_r;
    div_start_nxt = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = pos_r[IDX_W-1:0];
    mem_wdata = val_r;
    mem_raddr = idx_r[IDX_W-1:0];
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt = out_kind_r;
    out_med_nxt = out_med_r;
    out_mean_nxt = out_mean_r;
    out_top_nxt = out_top_r;
    out_modes_nxt = out_modes_r;
    out_val_nxt = out_val_r;
    out_ovf_nxt = out_ovf_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_sample;
          last_nxt = in_is_last;
          pos_nxt = count_r;
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            state_nxt = S_INS_RD;
          end else begin
            dropped_nxt = 1'b1;
            if (in_is_last) begin
              state_nxt = S_WALK_RD;
              pass_nxt = 2'd1;
              idx_nxt = '0;
              sum_nxt = '0;
              top_nxt = CNT_W'(1);
            end
          end
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
          count_nxt = count_r + 1'b1;
          if (last_r) begin
            state_nxt = S_WALK_RD;
            pass_nxt = 2'd1;
            idx_nxt = '0;
            sum_nxt = '0;
            top_nxt = CNT_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          mem_re = 1'b1;
          mem_raddr = IDX_W'(pos_r - 1'b1);
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_r > val_r) begin
          mem_wdata = rdata_r;
          pos_nxt = pos_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + 1'b1;
          if (last_r) begin
            state_nxt = S_WALK_RD;
            pass_nxt = 2'd1;
            idx_nxt = '0;
            sum_nxt = '0;
            top_nxt = CNT_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WALK_RD: begin
        mem_re = 1'b1;
        state_nxt = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        if (pass_r != 2'd3 || run_cur != top_r || out_free) begin
          prev_nxt = rdata_r;
          run_nxt = run_cur;
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_WALK_RD;
          case (pass_r)
            2'd1: begin
              sum_nxt = sum_r + SUM_W'(rdata_r);
              if (run_cur > top_r) begin
                top_nxt = run_cur;
              end
              if (idx_r == half - 1'b1) begin
                med_a_nxt = rdata_r;
              end
              if (idx_r == half) begin
                med_b_nxt = rdata_r;
              end
            end
            2'd2: begin
              if (run_cur == top_r) begin
                modes_nxt = modes_r + 1'b1;
              end
            end
            default: begin
              if (run_cur == top_r) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt = KIND_MODE;
                out_med_nxt = '0;
                out_mean_nxt = '0;
                out_top_nxt = '0;
                out_modes_nxt = '0;
                out_val_nxt = rdata_r;
                out_ovf_nxt = 1'b0;
                out_last_nxt = (emitted_r + 1'b1 == modes_r);
                emitted_nxt = emitted_r + 1'b1;
              end
            end
          endcase
          if (idx_r == count_r - 1'b1) begin
            idx_nxt = '0;
            case (pass_r)
              2'd1: begin
                state_nxt = S_DIV;
                div_start_nxt = 1'b1;
              end
              2'd2: begin
                state_nxt = S_SUMMARY;
              end
              default: begin
                state_nxt = S_IDLE;
                count_nxt = '0;
                dropped_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_WALK_RD;
          pass_nxt = 2'd2;
          modes_nxt = '0;
          mean_nxt = sum_r[SUM_W-1] ? -mean_mag : mean_mag;
        end
      end
      S_SUMMARY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt = KIND_SUMMARY;
          out_med_nxt = med_x2;
          out_mean_nxt = mean_r;
          out_top_nxt = top_r;
          out_modes_nxt = modes_r;
          out_val_nxt = '0;
          out_ovf_nxt = dropped_r;
          out_last_nxt = 1'b0;
          emitted_nxt = '0;
          pass_nxt = 2'd3;
          state_nxt = S_WALK_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      dropped_r <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dropped_r <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
    end
    last_r <= last_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    pass_r <= pass_nxt;
    idx_r <= idx_nxt;
    prev_r <= prev_nxt;
    run_r <= run_nxt;
    top_r <= top_nxt;
    modes_r <= modes_nxt;
    emitted_r <= emitted_nxt;
    sum_r <= sum_nxt;
    med_a_r <= med_a_nxt;
    med_b_r <= med_b_nxt;
    mean_r <= mean_nxt;
    out_kind_r <= out_kind_nxt;
    out_med_r <= out_med_nxt;
    out_mean_r <= out_mean_nxt;
    out_top_r <= out_top_nxt;
    out_modes_r <= out_modes_nxt;
    out_val_r <= out_val_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_median_x2 = out_med_r;
  assign out_mean_q8 = out_mean_r;
  assign out_top_frequency = out_top_r;
  assign out_mode_count = out_modes_r;
  assign out_mode_value = out_val_r;
  assign out_overflowed = out_ovf_r;
  assign out_last_result = out_last_r;

  `SMMM_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_ITEMS))
  `SMMM_ASSERT_NEXT(a_drop_flag, in_valid && !in_stall && count_r == CNT_W'(MAX_ITEMS), dropped_r)
  `SMMM_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_val_r) && $stable(out_kind_r))
endmodule

// ----- bench/tb_set_mode_median_mean_core.sv -----
module tb_set_mode_median_mean_core;
  import smmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic kind;
    logic signed [16:0] median_x2;
    logic signed [23:0] mean_q8;
    logic [5:0] top_frequency;
    logic [5:0] mode_count;
    logic signed [15:0] mode_value;
    logic overflowed;
    logic last_result;
  } stat_result_t;

  typedef struct {
    logic signed [15:0] sample;
    logic is_last;
    logic check_summary;
    logic signed [16:0] median_x2;
    logic signed [23:0] mean_q8;
    logic [5:0] top_frequency;
    logic [5:0] mode_count;
    logic overflowed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic signed [16:0] out_median_x2;
  logic signed [23:0] out_mean_q8;
  logic [5:0] out_top_frequency;
  logic [5:0] out_mode_count;
  logic signed [15:0] out_mode_value;
  logic out_overflowed;
  logic out_last_result;

  set_mode_median_mean_core dut (.*);

  always #5 clk = ~clk;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 56;
  int unsigned hold_cycles = 0;
  int errors = 0;
  int unsigned checked = 0;

  logic signed [15:0] sorted_set[$];
  logic set_dropped = 1'b0;
  stat_result_t expected_results[$];
  stim_row_t directed[$];

  task automatic report(input string what);
    $display("mismatch %0d: %s", checked, what);
    errors++;
  endtask

  task automatic predict_sample(input logic signed [15:0] v, input logic last);
    int pos;
    int n;
    int run;
    int top;
    int modes;
    longint sum;
    longint med;
    stat_result_t r;
    stat_result_t modes_q[$];
    if (sorted_set.size() < MAX_ITEMS) begin
      pos = sorted_set.size();
      while (pos > 0 && sorted_set[pos - 1] > v) pos--;
      sorted_set.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    n = sorted_set.size();
    if (n % 2) med = 2 * longint'(sorted_set[n / 2]);
    else med = longint'(sorted_set[n / 2 - 1]) + longint'(sorted_set[n / 2]);
    sum = 0;
    foreach (sorted_set[i]) sum += sorted_set[i];
    top = 1;
    run = 1;
    for (int i = 1; i < n; i++) begin
      run = (sorted_set[i] == sorted_set[i - 1]) ? run + 1 : 1;
      if (run > top) top = run;
    end
    run = 1;
    for (int i = 0; i < n; i++) begin
      if (i > 0) run = (sorted_set[i] == sorted_set[i - 1]) ? run + 1 : 1;
      if (run == top) begin
        r = '0;
        r.kind = KIND_MODE;
        r.mode_value = sorted_set[i];
        modes_q.push_back(r);
      end
    end
    modes = modes_q.size();
    r = '0;
    r.kind = KIND_SUMMARY;
    r.median_x2 = med[16:0];
    r.mean_q8 = 24'((sum * 256) / n);
    r.top_frequency = 6'(top);
    r.mode_count = 6'(modes);
    r.overflowed = set_dropped;
    modes_q.push_front(r);
    modes_q[modes].last_result = 1'b1;
    foreach (modes_q[i]) expected_results.push_back(modes_q[i]);
    sorted_set.delete();
    set_dropped = 1'b0;
  endtask

  task automatic send_sample(input logic signed [15:0] v, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= v;
    in_is_last <= last;
    predict_sample(v, last);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    send_idle();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set(input int len, input int flavor);
    logic signed [15:0] pool[4];
    logic signed [15:0] v;
    foreach (pool[i]) pool[i] = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      case (flavor)
        0: v = 16'($urandom);
        1: v = pool[$urandom_range(3)];
        2: v = 16'($signed($urandom_range(8)) - 4);
        default: v = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
      endcase
      send_sample(v, i == len - 1);
    end
  endtask

  task automatic add_row(input logic signed [15:0] v, input logic last,
                         input logic chk = 1'b0, input int med = 0, input int mean = 0,
                         input int top = 0, input int modes = 0, input logic ovf = 1'b0);
    stim_row_t row;
    row.sample = v;
    row.is_last = last;
    row.check_summary = chk;
    row.median_x2 = 17'(med);
    row.mean_q8 = 24'(mean);
    row.top_frequency = 6'(top);
    row.mode_count = 6'(modes);
    row.overflowed = ovf;
    directed.push_back(row);
  endtask

  always @(posedge clk) begin
    stat_result_t got;
    stat_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_median_x2, out_mean_q8, out_top_frequency, out_mode_count,
              out_mode_value, out_overflowed, out_last_result};
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) report($sformatf("kind %0d vs %0d", got.kind, want.kind));
        if (got.median_x2 !== want.median_x2)
          report($sformatf("median_x2 %0d vs %0d", got.median_x2, want.median_x2));
        if (got.mean_q8 !== want.mean_q8)
          report($sformatf("mean_q8 %0d vs %0d", got.mean_q8, want.mean_q8));
        if (got.top_frequency !== want.top_frequency)
          report($sformatf("top_frequency %0d vs %0d", got.top_frequency, want.top_frequency));
        if (got.mode_count !== want.mode_count)
          report($sformatf("mode_count %0d vs %0d", got.mode_count, want.mode_count));
        if (got.mode_value !== want.mode_value)
          report($sformatf("mode_value %0d vs %0d", got.mode_value, want.mode_value));
        if (got.overflowed !== want.overflowed)
          report($sformatf("overflowed %0d vs %0d", got.overflowed, want.overflowed));
        if (got.last_result !== want.last_result)
          report($sformatf("last_result %0d vs %0d", got.last_result, want.last_result));
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #50ms;
    $display("FAIL set_mode_median_mean_core");
    $finish;
  end

  initial begin
    int sent;
    int len;
    stat_result_t summary;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A set of one sample closes on its only sample.
    add_row(16'sd7, 1'b1, 1'b1, 14, 1792, 1, 1);
    add_row(16'sh7fff, 1'b0);
    add_row(16'sh7fff, 1'b1, 1'b1, 65534, 8388352, 2, 1);
    add_row(-16'sh8000, 1'b0);
    add_row(-16'sh8000, 1'b1, 1'b1, -65536, -8388608, 2, 1);
    add_row(16'sh7fff, 1'b0);
    add_row(-16'sh8000, 1'b1, 1'b1, -1, -128, 1, 2);
    add_row(16'sd3, 1'b0);
    add_row(16'sd1, 1'b0);
    add_row(16'sd1, 1'b1, 1'b1, 2, 426, 2, 1);
    add_row(-16'sd1, 1'b0);
    add_row(16'sd0, 1'b0);
    add_row(16'sd0, 1'b0);
    add_row(-16'sd1, 1'b1, 1'b1, -1, -128, 2, 2);
    add_row(16'sd5, 1'b0);
    add_row(-16'sd2, 1'b0);
    add_row(16'sd9, 1'b1);
    foreach (directed[i]) begin
      if (directed[i].check_summary) summary = '0;
      send_sample(directed[i].sample, directed[i].is_last);
      if (directed[i].check_summary) begin
        summary = expected_results[expected_results.size() - 1 - summary.kind];
        for (int j = expected_results.size() - 1; j >= 0; j--)
          if (expected_results[j].kind == KIND_SUMMARY) begin
            summary = expected_results[j];
            break;
          end
        if (summary.median_x2 !== directed[i].median_x2 ||
            summary.mean_q8 !== directed[i].mean_q8 ||
            summary.top_frequency !== directed[i].top_frequency ||
            summary.mode_count !== directed[i].mode_count ||
            summary.overflowed !== directed[i].overflowed)
          report($sformatf("directed row %0d summary differs from table", i));
      end
    end
    // Overfilled set: the closing sample is dropped as well.
    for (int i = 0; i < MAX_ITEMS + 3; i++) send_sample(16'(i), i == MAX_ITEMS + 2);
    drain();

    // Long receiver hold: a full set closes and its results back up, and the
    // sender keeps offering the next set against a stalled input.
    hold_cycles = 4000;
    send_random_set(MAX_ITEMS, 1);
    send_random_set(4, 0);
    drain();

    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 56 : 0;
      recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 6 : 0;
      while (sent < 140 * (ph + 1)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(MAX_ITEMS, MAX_ITEMS + 4)
                                       : $urandom_range(2, 12);
        send_random_set(len, $urandom_range(3));
        sent += len;
        if ($urandom_range(7) == 0) drain();
      end
    end
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS set_mode_median_mean_core");
    end else begin
      $display("FAIL set_mode_median_mean_core");
    end
    $finish;
  end
endmodule
